### hw/rtl/ccs_pkg.sv
package ccs_pkg;

    // Phase folding pivots (pi/2 and 3*pi/2 in phase units)
    localparam logic [31:0] PIVOT_Q1 = 32'h3fff_ffff;
    localparam logic [31:0] PIVOT_Q3 = 32'hbfff_fffd;

    // Inverse CORDIC gain word, s0.31 (about -0.607)
    localparam logic signed [31:0] GAIN_WORD = 32'shb245_8939;

    // Default rotation step count and arctangent table depth
    localparam int unsigned ROTATION_STEPS_DEFAULT = 31;
    localparam int unsigned ATAN_DEPTH = 32;

    // Arctangent of 2^-i, pi = 0xffffffff / 2
    localparam logic [31:0] ARCTAN_LUT [ATAN_DEPTH] = '{
        32'h1fffffff, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
        32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000a, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Working vector and angle handed from cell to cell
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        z;
    } stage_t;

endpackage

### hw/rtl/ccs_fold.sv
module ccs_fold (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [31:0]     phase,
    output logic            out_valid,
    output ccs_pkg::stage_t out_stage
);
    import ccs_pkg::*;

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    // Quadrant fold: start vector sign and angle offset
    always_comb
    begin
        stage_next.y = '0;
        if (phase < PIVOT_Q1)
        begin
            stage_next.x = -GAIN_WORD;
            stage_next.z = phase + PIVOT_Q1;
        end
        else if (phase < PIVOT_Q3)
        begin
            stage_next.x = GAIN_WORD;
            stage_next.z = phase - PIVOT_Q1;
        end
        else
        begin
            stage_next.x = -GAIN_WORD;
            stage_next.z = phase - PIVOT_Q3;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

### hw/rtl/ccs_cell.sv
module ccs_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ccs_pkg::stage_t in_stage,
    output logic            out_valid,
    output ccs_pkg::stage_t out_stage
);
    import ccs_pkg::*;

    localparam int unsigned SHIFT = STEP % ATAN_DEPTH;
    localparam logic [31:0] ANGLE = ARCTAN_LUT[SHIFT];

    logic               valid_reg;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic signed [31:0] x_shift;
    logic signed [31:0] y_shift;
    logic               rotate_neg;

    // One micro-rotation; direction set by z against the pivot
    always_comb
    begin
        x_shift    = in_stage.x >>> SHIFT;
        y_shift    = in_stage.y >>> SHIFT;
        rotate_neg = (in_stage.z >= PIVOT_Q1);
        if (rotate_neg)
        begin
            stage_next.x = in_stage.x - y_shift;
            stage_next.y = in_stage.y + x_shift;
            stage_next.z = in_stage.z - ANGLE;
        end
        else
        begin
            stage_next.x = in_stage.x + y_shift;
            stage_next.y = in_stage.y - x_shift;
            stage_next.z = in_stage.z + ANGLE;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

### hw/rtl/cordic_sine_cosine_unit.sv
// Phase to sine/cosine, circular CORDIC, one register per rotation cell.
// Start to done passes the fold register and then each rotation cell register.
// Throughput: one request per cycle; busy is never raised, the fold stage
// and the chain of rotation cells each take a new request every cycle.
// Reset (rst_n, async, active low) clears the valid flags; no request in
// flight survives it. The receiver cannot stall: done pulses for one cycle.
module cordic_sine_cosine_unit #(
    parameter int unsigned ROTATION_STEPS = ccs_pkg::ROTATION_STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        phase,
    output logic               done,
    output logic signed [31:0] sine,
    output logic signed [31:0] cosine
);
    import ccs_pkg::*;

    logic                      accepted;
    logic [ROTATION_STEPS:0]   valid_chain;
    stage_t                    stage_chain [ROTATION_STEPS+1];

    // Pipeline never stalls
    assign busy     = 1'b0;
    assign accepted = start && !busy;

    // Quadrant fold
    ccs_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accepted),
        .phase     (phase),
        .out_valid (valid_chain[0]),
        .out_stage (stage_chain[0])
    );

    // Chain of rotation cells
    for (genvar k = 0; k < ROTATION_STEPS; k++)
    begin : g_cell
        ccs_cell #(
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[k]),
            .in_stage  (stage_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_stage (stage_chain[k+1])
        );
    end

    assign done   = valid_chain[ROTATION_STEPS];
    assign sine   = stage_chain[ROTATION_STEPS].y;
    assign cosine = stage_chain[ROTATION_STEPS].x;

`ifndef SYNTHESIS
    a_fold_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> valid_chain[0])
        else $error("fold stage missed an accepted request");
    a_fold_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        !accepted |=> !valid_chain[0])
        else $error("fold stage valid without a request");
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(valid_chain[0], ROTATION_STEPS))
        else $error("done does not follow the fold stage by the chain length");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a non-stalling pipeline");
`endif

endmodule

### tb/sv/cordic_sine_cosine_unit_test.sv
module cordic_sine_cosine_unit_test;

    import ccs_pkg::*;

    localparam int unsigned STEPS        = ROTATION_STEPS_DEFAULT;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          TAIL_ITEMS   = 200;   // no idling for the last requests
    localparam int          DRAIN_CYCLES = STEPS + 8;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          SHOW_LIMIT   = 10;

    // Which quadrant fold a phase takes
    typedef enum logic [1:0] {
        FOLD_LOW,
        FOLD_MID,
        FOLD_HIGH
    } fold_e;

    typedef struct {
        logic [31:0]        phase;
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } sincos_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [31:0]        phase = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;

    logic [31:0] phase_backlog [$];
    sincos_t     expected_sincos [$];

    int gap_left = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    int fold_hits [3] = '{0, 0, 0};

    cordic_sine_cosine_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .phase  (phase),
        .done   (done),
        .sine   (sine),
        .cosine (cosine)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic fold_e fold_of(input logic [31:0] ph);
        if (ph < PIVOT_Q1)
            return FOLD_LOW;
        else if (ph < PIVOT_Q3)
            return FOLD_MID;
        return FOLD_HIGH;
    endfunction

    // Fold the phase, then run the micro-rotations with wrapping x/y
    function automatic sincos_t rotate_phase(input logic [31:0] ph);
        sincos_t            res;
        logic signed [31:0] xv;
        logic signed [31:0] yv;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic [31:0]        zv;
        xv = GAIN_WORD;
        yv = '0;
        case (fold_of(ph))
            FOLD_LOW:
            begin
                xv = -xv;
                zv = ph + PIVOT_Q1;
            end
            FOLD_MID:
                zv = ph - PIVOT_Q1;
            default:
            begin
                xv = -xv;
                zv = ph - PIVOT_Q3;
            end
        endcase
        for (int i = 0; i < STEPS; i++)
        begin
            xs = xv >>> (i % 32);
            ys = yv >>> (i % 32);
            if (zv >= PIVOT_Q1)
            begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - ARCTAN_LUT[i % 32];
            end
            else
            begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + ARCTAN_LUT[i % 32];
            end
        end
        res.phase  = ph;
        res.sine   = yv;
        res.cosine = xv;
        return res;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= SHOW_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Driver: launch requests from the backlog, with random idle bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_sincos.push_back(rotate_phase(phase));
                fold_hits[fold_of(phase)]++;
                requests_taken++;
            end
            if (start && busy)
                ;   // hold the request until it is taken
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (phase_backlog.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
            begin
                start <= 1'b0;
                gap_left = $urandom_range(0, 12);
            end
            else if (phase_backlog.size() > 0)
            begin
                start <= 1'b1;
                phase <= phase_backlog.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        sincos_t want;
        if (rst_n && done)
        begin
            if (expected_sincos.size() == 0)
                note_error($sformatf("result with nothing pending: sine %0d cosine %0d",
                                     sine, cosine));
            else
            begin
                want = expected_sincos.pop_front();
                results_checked++;
                if (sine !== want.sine)
                    note_error($sformatf("phase %08h sine expected %0d got %0d",
                                         want.phase, want.sine, sine));
                if (cosine !== want.cosine)
                    note_error($sformatf("phase %08h cosine expected %0d got %0d",
                                         want.phase, want.cosine, cosine));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] corner [$];
        logic [31:0] pivot;
        // Fold boundaries, octant points and bit patterns
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h3fff_fffe, 32'h3fff_ffff,
                   32'h4000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hbfff_fffc,
                   32'hbfff_fffd, 32'hbfff_fffe, 32'hffff_fffe, 32'hffff_ffff,
                   32'h2000_0000, 32'h6000_0000, 32'ha000_0000, 32'he000_0000,
                   32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hfedc_ba98};
        foreach (corner[k])
            phase_backlog.push_back(corner[k]);

        // Mostly uniform phases, some clustered around the fold pivots, zero and pi
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0: pivot = PIVOT_Q1;
                        1: pivot = PIVOT_Q3;
                        2: pivot = 32'h0000_0000;
                        default: pivot = 32'h8000_0000;
                    endcase
                    phase_backlog.push_back(pivot + $urandom_range(0, 64) - 32);
                end
                1: phase_backlog.push_back($urandom >> $urandom_range(0, 31));
                default: phase_backlog.push_back($urandom);
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (phase_backlog.size() != 0 || start)
            @(posedge clk);
        while (expected_sincos.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d phases; fold hits low/mid/high: %0d/%0d/%0d",
                 results_checked, requests_taken,
                 fold_hits[FOLD_LOW], fold_hits[FOLD_MID], fold_hits[FOLD_HIGH]);
        $display("Errors: %0d (first %0d shown)", error_count, SHOW_LIMIT);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
